// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is asserted.
`define ETQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ETQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/etq_pkg.sv =====
// Types, constants and codes of the expiry timer queue.
`default_nettype none
package etq_pkg;
	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int MAX_RESULTS = 32;
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);

	localparam logic [2:0] OP_ADD_A = 3'd0;
	localparam logic [2:0] OP_ADD_B = 3'd1;
	localparam logic [2:0] OP_CANCEL_OWNER = 3'd2;
	localparam logic [2:0] OP_CANCEL_PARAM = 3'd3;
	localparam logic [2:0] OP_TICK = 3'd4;

	localparam logic [1:0] KIND_FIRE_A = 2'd0;
	localparam logic [1:0] KIND_CANCEL = 2'd1;
	localparam logic [1:0] KIND_FIRE_B = 2'd2;
	localparam logic [1:0] KIND_REJECT = 2'd3;

	typedef struct packed {
		logic valid;
		logic [31:0] expiry;
		logic [15:0] owner;
		logic signed [31:0] param;
	} entry_t;

	typedef struct packed {
		logic add;
		logic remove;
		logic [IDX_W-1:0] rm_idx;
	} qcmd_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/etq_cell.sv =====
// One timer slot: holds an entry, loads a new one or takes its neighbor's.
`default_nettype none
module etq_cell (
	input wire logic clk,
	input wire logic arst_n,
	input wire etq_pkg::cell_ctl_t ctl,
	input wire etq_pkg::entry_t nbr,
	input wire etq_pkg::entry_t add_data,
	output etq_pkg::entry_t q
);
	import etq_pkg::*;

	logic valid_q;
	logic [31:0] expiry_q;
	logic [15:0] owner_q;
	logic signed [31:0] param_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= nbr.valid;
		end else if (ctl.load) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			expiry_q <= nbr.expiry;
			owner_q <= nbr.owner;
			param_q <= nbr.param;
		end else if (ctl.load) begin
			expiry_q <= add_data.expiry;
			owner_q <= add_data.owner;
			param_q <= add_data.param;
		end
	end

	assign q = '{valid: valid_q, expiry: expiry_q, owner: owner_q, param: param_q};
endmodule
`default_nettype wire

// ===== rtl/etq_queue.sv =====
// One compacted timer queue built as a chain of slots.
`default_nettype none
module etq_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire etq_pkg::qcmd_t cmd,
	input wire etq_pkg::entry_t add_data,
	input wire logic [etq_pkg::IDX_W-1:0] rd_idx,
	output etq_pkg::entry_t rd,
	output logic full
);
	import etq_pkg::*;

	entry_t cq [QUEUE_DEPTH];

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		cell_ctl_t ctl;
		entry_t nbr;
		logic prev_valid;

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = cq[i+1];
		end
		if (i == 0) begin : g_first
			assign prev_valid = 1'b1;
		end else begin : g_rest
			assign prev_valid = cq[i-1].valid;
		end

		// close the gap left by a removal: every slot at or above it moves down
		assign ctl.shift = cmd.remove && (IDX_W'(i) >= cmd.rm_idx);
		assign ctl.load = cmd.add && !cq[i].valid && prev_valid;

		etq_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.nbr(nbr),
			.add_data(add_data),
			.q(cq[i])
		);
	end

	assign rd = cq[rd_idx];
	assign full = cq[QUEUE_DEPTH-1].valid;
endmodule
`default_nettype wire

// ===== rtl/expiry_timer_queue_unit.sv =====
// Top level of the expiry timer queue: command sequencer, two slot chains, output stage.
//
// Takes one command at a time. A cancel walks the slot chain one slot a cycle
// while the output does not stall, staying on a slot when it removes it,
// through queue A (and queue B for cancel-owner). A tick sweeps a queue once
// per fired entry, one slot a cycle while the output does not stall, to find
// the earliest due entry, plus one sweep per queue to find nothing left.
// A result beat is held one step back so last_of_run can be marked; output
// stalls hold the sequencer. No clearing pass after reset.
`default_nettype none
module expiry_timer_queue_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [2:0] opcode,
	input wire logic [31:0] now_seconds,
	input wire logic [31:0] delay_seconds,
	input wire logic [15:0] owner_id,
	input wire logic signed [31:0] timer_param,
	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] event_kind,
	output logic [15:0] event_owner,
	output logic signed [31:0] event_param,
	output logic last_of_run
);
	import etq_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DISP = 3'd1;
	localparam logic [2:0] S_CAN = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_FIRE = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

	logic [2:0] state_q;
	logic [2:0] op_q;
	logic [31:0] now_q;
	logic [31:0] expiry_q;
	logic [15:0] owner_q;
	logic signed [31:0] param_q;
	logic qsel_q;
	logic [IDX_W-1:0] ptr_q;
	logic best_v_q;
	logic [IDX_W-1:0] best_idx_q;
	entry_t best_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0] last_tick_q;
	logic pend_v_q;
	logic [1:0] pend_kind_q;
	logic [15:0] pend_owner_q;
	logic signed [31:0] pend_param_q;
	logic out_valid_q;
	logic [1:0] out_kind_q;
	logic [15:0] out_owner_q;
	logic signed [31:0] out_param_q;
	logic out_last_q;

	entry_t rd_a, rd_b, rd, add_data;
	logic full_a, full_b;
	qcmd_t cmd, cmd_a, cmd_b;
	logic go, cap, match, due, scan_end, at_end;
	logic emit_v;
	logic load_out;
	logic [1:0] emit_kind;
	logic [15:0] emit_owner;
	logic signed [31:0] emit_param;
	logic [32:0] sum;

	assign go = !out_valid_q || out_ready;
	assign rd = qsel_q ? rd_b : rd_a;
	assign cap = cnt_q != CNT_W'(MAX_RESULTS);
	assign match = rd.valid && (rd.owner == owner_q) &&
		((op_q != OP_CANCEL_PARAM) || (rd.param == param_q));
	assign due = rd.valid && (rd.expiry <= now_q) &&
		(!best_v_q || (rd.expiry < best_q.expiry));
	assign scan_end = !rd.valid || (ptr_q == LAST_IDX);
	assign at_end = !cap || !rd.valid || (!match && ptr_q == LAST_IDX);
	assign add_data = '{valid: 1'b1, expiry: expiry_q, owner: owner_q, param: param_q};
	assign sum = {1'b0, now_seconds} + {1'b0, delay_seconds};
	assign load_out = pend_v_q && (emit_v || (state_q == S_DONE && go));

	always_comb begin
		emit_v = 1'b0;
		emit_kind = KIND_CANCEL;
		emit_owner = rd.owner;
		emit_param = rd.param;
		cmd = '0;
		unique case (state_q)
			S_DISP: begin
				if (go && (op_q == OP_ADD_A || op_q == OP_ADD_B)) begin
					if (qsel_q ? full_b : full_a) begin
						emit_v = 1'b1;
						emit_kind = KIND_REJECT;
						emit_owner = owner_q;
						emit_param = param_q;
					end else begin
						cmd.add = 1'b1;
					end
				end
			end
			S_CAN: begin
				if (go && cap && match) begin
					emit_v = 1'b1;
					cmd.remove = 1'b1;
					cmd.rm_idx = ptr_q;
				end
			end
			S_FIRE: begin
				if (go && cap && best_v_q) begin
					emit_v = 1'b1;
					emit_kind = qsel_q ? KIND_FIRE_B : KIND_FIRE_A;
					emit_owner = best_q.owner;
					emit_param = best_q.param;
					cmd.remove = 1'b1;
					cmd.rm_idx = best_idx_q;
				end
			end
			default: begin
			end
		endcase
		cmd_a = qsel_q ? '0 : cmd;
		cmd_b = qsel_q ? cmd : '0;
	end

	etq_queue u_queue_a (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_a), .add_data(add_data),
		.rd_idx(ptr_q), .rd(rd_a), .full(full_a)
	);

	etq_queue u_queue_b (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_b), .add_data(add_data),
		.rd_idx(ptr_q), .rd(rd_b), .full(full_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= '0;
			now_q <= '0;
			expiry_q <= '0;
			owner_q <= '0;
			param_q <= '0;
			qsel_q <= 1'b0;
			ptr_q <= '0;
			best_v_q <= 1'b0;
			best_idx_q <= '0;
			best_q <= '0;
			cnt_q <= '0;
			last_tick_q <= '0;
			pend_v_q <= 1'b0;
			pend_kind_q <= '0;
			pend_owner_q <= '0;
			pend_param_q <= '0;
			out_valid_q <= 1'b0;
			out_kind_q <= '0;
			out_owner_q <= '0;
			out_param_q <= '0;
			out_last_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			// hold each result one step back until the next one shows up
			if (emit_v) begin
				if (pend_v_q) begin
					out_kind_q <= pend_kind_q;
					out_owner_q <= pend_owner_q;
					out_param_q <= pend_param_q;
					out_last_q <= 1'b0;
				end
				pend_v_q <= 1'b1;
				pend_kind_q <= emit_kind;
				pend_owner_q <= emit_owner;
				pend_param_q <= emit_param;
				cnt_q <= cnt_q + CNT_W'(1);
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q <= opcode;
						now_q <= now_seconds;
						expiry_q <= sum[32] ? '1 : sum[31:0];
						owner_q <= owner_id;
						param_q <= timer_param;
						qsel_q <= (opcode == OP_ADD_B);
						cnt_q <= '0;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					if (go) begin
						ptr_q <= '0;
						best_v_q <= 1'b0;
						priority if (op_q == OP_CANCEL_OWNER || op_q == OP_CANCEL_PARAM) begin
							state_q <= S_CAN;
						end else if (op_q == OP_TICK) begin
							if (last_tick_q < now_q) begin
								last_tick_q <= now_q;
								qsel_q <= 1'b0;
							end else begin
								qsel_q <= 1'b1;
							end
							state_q <= S_SCAN;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_CAN: begin
					if (go) begin
						priority if (at_end) begin
							if (!qsel_q && cap && op_q == OP_CANCEL_OWNER) begin
								qsel_q <= 1'b1;
								ptr_q <= '0;
							end else begin
								state_q <= S_DONE;
							end
						end else if (!match) begin
							ptr_q <= ptr_q + IDX_W'(1);
						end
					end
				end
				S_SCAN: begin
					if (go) begin
						if (!cap) begin
							state_q <= S_DONE;
						end else begin
							if (due) begin
								best_v_q <= 1'b1;
								best_idx_q <= ptr_q;
								best_q <= rd;
							end
							if (scan_end) begin
								state_q <= S_FIRE;
							end else begin
								ptr_q <= ptr_q + IDX_W'(1);
							end
						end
					end
				end
				S_FIRE: begin
					if (go) begin
						ptr_q <= '0;
						best_v_q <= 1'b0;
						priority if (best_v_q && cap) begin
							state_q <= S_SCAN;
						end else if (!qsel_q && cap) begin
							qsel_q <= 1'b1;
							state_q <= S_SCAN;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (go) begin
						if (pend_v_q) begin
							out_kind_q <= pend_kind_q;
							out_owner_q <= pend_owner_q;
							out_param_q <= pend_param_q;
							out_last_q <= 1'b1;
							pend_v_q <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign event_kind = out_kind_q;
	assign event_owner = out_owner_q;
	assign event_param = out_param_q;
	assign last_of_run = out_last_q;
endmodule
`default_nettype wire

// ===== rtl/etq_checker.sv =====
// Port-level checks of the expiry timer queue, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module etq_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [1:0] event_kind,
	input wire logic [15:0] event_owner,
	input wire logic last_of_run
);
	import etq_pkg::*;

	`ETQ_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(event_owner), "stalled result beat changed")
	`ETQ_ASSERT(a_busy_after_accept, clk, arst_n, in_valid && in_ready |=> !in_ready, "command taken while busy")
	`ETQ_ASSERT(a_reject_alone, clk, arst_n, out_valid && event_kind == KIND_REJECT |-> last_of_run, "reject beat not last of run")
	`ETQ_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |=> !out_valid, "result beat during reset")
endmodule

bind expiry_timer_queue_unit etq_checker u_etq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.event_kind(event_kind),
	.event_owner(event_owner),
	.last_of_run(last_of_run)
);
`default_nettype wire

// ===== tb/sv/expiry_timer_queue_unit_tb.sv =====
// Self-checking testbench for the expiry timer queue: directed rows, then random command traffic.
`default_nettype none
module expiry_timer_queue_unit_tb;
	import etq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 200000;

	typedef struct {
		logic [1:0] kind;
		logic [15:0] owner;
		logic signed [31:0] param;
		logic last;
	} timer_event_t;

	typedef struct {
		logic [31:0] expiry;
		logic [15:0] owner;
		logic signed [31:0] param;
	} slot_t;

	typedef struct {
		logic [2:0] op;
		logic [31:0] now;
		logic [31:0] delay;
		logic [15:0] owner;
		logic signed [31:0] param;
		int n_typed;
		logic [1:0] kind0;
		logic [15:0] owner0;
		logic signed [31:0] param0;
	} cmd_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] opcode = '0;
	logic [31:0] now_seconds = '0;
	logic [31:0] delay_seconds = '0;
	logic [15:0] owner_id = '0;
	logic signed [31:0] timer_param = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] event_kind;
	logic [15:0] event_owner;
	logic signed [31:0] event_param;
	logic last_of_run;

	slot_t queue_a[$];
	slot_t queue_b[$];
	logic [31:0] last_tick;
	timer_event_t pending_events[$];
	timer_event_t step_events[$];

	int mismatches = 0;
	int beats_in = 0;
	int beats_out = 0;
	int idle_cycles = 0;
	bit hold_off = 1'b0;
	bit stim_done = 1'b0;
	logic [31:0] wall = 32'd100;

	expiry_timer_queue_unit DUT (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void note(logic [1:0] k, logic [15:0] o, logic signed [31:0] p);
		timer_event_t e;
		e.kind = k; e.owner = o; e.param = p; e.last = 1'b0;
		step_events = {step_events, e};
	endfunction

	// pick earliest due entry, first added wins ties
	function automatic void fire_queue(ref slot_t q[$], input logic [31:0] now,
			input logic [1:0] k);
		int best;
		while (step_events.size() < MAX_RESULTS) begin
			best = -1;
			foreach (q[i])
				if (q[i].expiry <= now && (best < 0 || q[i].expiry < q[best].expiry))
					best = i;
			if (best < 0)
				break;
			note(k, q[best].owner, q[best].param);
			q.delete(best);
		end
	endfunction

	function automatic void cancel_queue(ref slot_t q[$], input logic [15:0] o,
			input bit by_param, input logic signed [31:0] p);
		int i;
		i = 0;
		while (i < q.size()) begin
			if (step_events.size() < MAX_RESULTS && q[i].owner == o
					&& (!by_param || q[i].param == p)) begin
				note(KIND_CANCEL, q[i].owner, q[i].param);
				q.delete(i);
			end else
				i++;
		end
	endfunction

	function automatic void add_queue(ref slot_t q[$], input slot_t s);
		if (q.size() >= QUEUE_DEPTH)
			note(KIND_REJECT, s.owner, s.param);
		else
			q = {q, s};
	endfunction

	function automatic void predict_timer_events(cmd_row_t c);
		slot_t s;
		logic [32:0] sum;
		step_events.delete();
		sum = {1'b0, c.now} + {1'b0, c.delay};
		s.expiry = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		s.owner = c.owner;
		s.param = c.param;
		case (c.op)
			OP_ADD_A: add_queue(queue_a, s);
			OP_ADD_B: add_queue(queue_b, s);
			OP_CANCEL_OWNER: begin
				cancel_queue(queue_a, c.owner, 1'b0, '0);
				cancel_queue(queue_b, c.owner, 1'b0, '0);
			end
			OP_CANCEL_PARAM: cancel_queue(queue_a, c.owner, 1'b1, c.param);
			OP_TICK: begin
				if (last_tick < c.now) begin
					last_tick = c.now;
					fire_queue(queue_a, c.now, KIND_FIRE_A);
				end
				fire_queue(queue_b, c.now, KIND_FIRE_B);
			end
			default: ;
		endcase
		if (step_events.size() > 0)
			step_events[step_events.size() - 1].last = 1'b1;
	endfunction

	// drop valid before an idle gap; with no gap the next beat follows at once
	task automatic send_command(cmd_row_t c, int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		predict_timer_events(c);
		if (c.n_typed > 0 && (step_events.size() != c.n_typed
				|| step_events[0].kind != c.kind0 || step_events[0].owner != c.owner0
				|| step_events[0].param != c.param0)) begin
			mismatches++;
			if (mismatches <= 10) begin
				if (step_events.size() > 0)
					$display("directed op %0d: exp %0d beats, first %0d %h %h; got %0d, first %0d %h %h",
						c.op, c.n_typed, c.kind0, c.owner0, c.param0, step_events.size(),
						step_events[0].kind, step_events[0].owner, step_events[0].param);
				else
					$display("directed op %0d: exp %0d beats, got none", c.op, c.n_typed);
			end
		end
		foreach (step_events[i])
			pending_events = {pending_events, step_events[i]};
		in_valid <= 1'b1;
		opcode <= c.op;
		now_seconds <= c.now;
		delay_seconds <= c.delay;
		owner_id <= c.owner;
		timer_param <= c.param;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	function automatic cmd_row_t mk(logic [2:0] op, logic [31:0] now, logic [31:0] delay,
			logic [15:0] owner, logic signed [31:0] param, int n = 0,
			logic [1:0] k = '0);
		cmd_row_t c;
		c.op = op; c.now = now; c.delay = delay; c.owner = owner; c.param = param;
		c.n_typed = n; c.kind0 = k; c.owner0 = owner; c.param0 = param;
		return c;
	endfunction

	// biased random command: adds and ticks dominate so entries actually fire
	function automatic cmd_row_t random_command();
		cmd_row_t c;
		int r;
		r = $urandom_range(0, 99);
		c = mk(OP_TICK, wall, '0, 16'($urandom_range(0, 7)), 32'($urandom_range(0, 3)));
		if ($urandom_range(0, 9) == 0) begin
			c.owner = 16'($urandom);
			c.param = $urandom;
		end
		if (r < 28)
			c.op = OP_ADD_A;
		else if (r < 50)
			c.op = OP_ADD_B;
		else if (r < 58)
			c.op = OP_CANCEL_OWNER;
		else if (r < 66)
			c.op = OP_CANCEL_PARAM;
		else if (r < 68)
			c.op = 3'($urandom_range(5, 7));
		if (c.op == OP_ADD_A || c.op == OP_ADD_B)
			c.delay = ($urandom_range(0, 19) == 0) ? $urandom : 32'($urandom_range(0, 6));
		if (c.op == OP_TICK && $urandom_range(0, 2) != 0)
			wall = wall + 32'($urandom_range(0, 3));
		c.now = ($urandom_range(0, 29) == 0) ? $urandom : wall;
		c.delay = (c.op <= OP_ADD_B) ? c.delay : $urandom;
		return c;
	endfunction

	initial begin
		cmd_row_t rows[$];
		cmd_row_t c;
		last_tick = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows = {rows, mk(OP_TICK, 32'd0, '0, 16'd0, 32'sd0)};
		rows = {rows, mk(OP_CANCEL_OWNER, 32'd5, '0, 16'hFFFF, 32'sd0)};
		rows = {rows, mk(OP_ADD_A, 32'd10, 32'd0, 16'h0000, 32'sh7FFF_FFFF)};
		rows = {rows, mk(OP_ADD_A, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 16'hFFFF,
			-32'sh8000_0000)};
		rows = {rows, mk(OP_ADD_B, 32'd10, 32'd2, 16'h1234, 32'sd7)};
		rows = {rows, mk(OP_ADD_B, 32'd10, 32'd1, 16'h1234, -32'sd1)};
		rows = {rows, mk(OP_TICK, 32'd10, '0, 16'h0000, 32'sh7FFF_FFFF, 1, KIND_FIRE_A)};
		rows = {rows, mk(OP_TICK, 32'd10, '0, '0, '0)};
		rows = {rows, mk(OP_TICK, 32'd12, '0, '0, '0)};
		rows = {rows, mk(3'd5, 32'd12, 32'd1, 16'hFFFF, 32'sd1)};
		rows = {rows, mk(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, -32'sd1)};
		rows = {rows, mk(OP_ADD_A, 32'd12, 32'd5, 16'h00AA, 32'sd3)};
		rows = {rows, mk(OP_ADD_A, 32'd12, 32'd5, 16'h00AA, 32'sd4)};
		rows = {rows, mk(OP_CANCEL_PARAM, 32'd12, '0, 16'h00AA, 32'sd4, 1, KIND_CANCEL)};
		rows = {rows, mk(OP_CANCEL_OWNER, 32'd12, '0, 16'hFFFF, '0)};
		rows = {rows, mk(OP_CANCEL_OWNER, 32'd12, '0, 16'h00AA, 32'sd3, 1, KIND_CANCEL)};
		for (int i = 0; i < QUEUE_DEPTH; i++)
			rows = {rows, mk(OP_ADD_B, 32'd20, 32'd1, 16'(i), 32'(i))};
		rows = {rows, mk(OP_ADD_B, 32'd20, 32'd1, 16'h0BAD, 32'sd99, 1, KIND_REJECT)};
		rows = {rows, mk(OP_TICK, 32'hFFFF_FFFF, '0, '0, '0)};
		foreach (rows[i])
			send_command(rows[i], $urandom_range(0, 2));

		for (int i = 0; i < 400; i++) begin
			c = random_command();
			if (i == 120)
				hold_off = 1'b1;
			if (i == 250 || i == 330) begin
				in_valid <= 1'b0;
				@(posedge clk);
				wait (pending_events.size() == 0);
			end
			send_command(c, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0);
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// receiver: random stalls, one long hold-off
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (600) @(posedge clk);
				hold_off = 1'b0;
			end
			w = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
			if (w > 0) begin
				out_ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!(out_valid && out_ready))
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		timer_event_t e;
		if (in_valid && in_ready)
			beats_in++;
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (arst_n && out_valid && out_ready) begin
			beats_out++;
			if (pending_events.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat kind %0d owner %h param %h", event_kind,
						event_owner, event_param);
			end else begin
				e = pending_events.pop_front();
				if (e.kind !== event_kind || e.owner !== event_owner
						|| e.param !== event_param || e.last !== last_of_run) begin
					mismatches++;
					if (mismatches <= 10)
						$display("beat %0d: exp kind %0d owner %h param %h last %b, got %0d %h %h %b",
							beats_out, e.kind, e.owner, e.param, e.last,
							event_kind, event_owner, event_param, last_of_run);
				end
			end
		end
	end

	initial begin
		int drain;
		drain = 0;
		while (!(stim_done && pending_events.size() == 0) && idle_cycles < STALL_LIMIT)
			@(posedge clk);
		while (drain < 2000 && idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		$display("covered %0d commands and %0d events over adds, cancels, ticks, rejects",
			beats_in, beats_out);
		if (idle_cycles >= STALL_LIMIT || pending_events.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire
